// File: rtl/float_matrix_row_to_fixed_pack_core_assert.svh
// Assertion macros for the float row to fixed pack core.
// Included by RTL files that carry concurrent checks.
`ifndef FLOAT_MATRIX_ROW_TO_FIXED_PACK_CORE_ASSERT_SVH
`define FLOAT_MATRIX_ROW_TO_FIXED_PACK_CORE_ASSERT_SVH

// Check a property on every edge outside reset.
`define FMR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every edge, reset included.
`define FMR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/fmr_pkg.sv
// Package for the float row to fixed pack core: widths, constants, stage types.
// No dependencies.
package fmr_pkg;

    localparam int unsigned ElemW     = 32;
    localparam int unsigned RowW      = 2;
    localparam int unsigned HalfW     = 16;
    localparam int unsigned NumElem   = 4;
    localparam int unsigned MantW     = 24;
    localparam int unsigned ProdW     = 2 * MantW;
    // Register stages in one conversion lane
    localparam int unsigned PipeDepth = 4;

    localparam logic [ElemW-1:0] ScaleReset = 32'h4780_0000;
    localparam logic [ElemW-1:0] FixMax     = 32'h7fff_ffff;
    localparam logic [ElemW-1:0] FixMin     = 32'h8000_0000;

    // Configuration register indexes
    localparam logic CfgLinear      = 1'b0;
    localparam logic CfgTranslation = 1'b1;

    // Special-case class of one product
    typedef enum logic [1:0] {
        t_cls_num  = 2'd0,
        t_cls_zero = 2'd1,
        t_cls_inf  = 2'd2,
        t_cls_nan  = 2'd3
    } t_cls;

    // Unpacked operand pair after stage one
    typedef struct packed {
        logic             sign;
        t_cls             cls;
        logic [9:0]       exp_sum;   // ea + eb, unbiased-adjust later
        logic [MantW-1:0] ma;
        logic [MantW-1:0] mb;
    } t_unp;

    // Product after stage two
    typedef struct packed {
        logic             sign;
        t_cls             cls;
        logic [9:0]       exp_sum;
        logic [ProdW-1:0] prod;
    } t_mul;

    // Normalised product after stage three, ready for rounding
    typedef struct packed {
        logic             sign;
        t_cls             cls;
        logic [11:0]      ie;        // signed exponent of the mantissa's leading bit
        logic [MantW-1:0] m;
        logic             g;
        logic             s;
    } t_nrm;

endpackage

// File: rtl/fmr_conv_lane.sv
// One lane: float32 multiply, round to float32, truncate to signed 32-bit.
// Four register stages: unpack, multiply, normalise, round+convert. Uses fmr_pkg.
module fmr_conv_lane (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [fmr_pkg::ElemW-1:0] i_a,
    input  logic [fmr_pkg::ElemW-1:0] i_b,
    output logic [fmr_pkg::ElemW-1:0] o_fix
);

    localparam int unsigned ProdW_L = fmr_pkg::ProdW;

    fmr_pkg::t_unp r_unp, n_unp;
    fmr_pkg::t_mul r_mul, n_mul;
    fmr_pkg::t_nrm r_nrm, n_nrm;
    logic [fmr_pkg::ElemW-1:0] r_fix, n_fix;

    // Unpack both operands and classify
    always_comb begin
        logic [7:0] ea, eb;
        logic za, zb, ia, ib, na, nb;
        ea = i_a[30:23];
        eb = i_b[30:23];
        za = (ea == 8'd0) && (i_a[22:0] == 23'd0);
        zb = (eb == 8'd0) && (i_b[22:0] == 23'd0);
        ia = (ea == 8'hff) && (i_a[22:0] == 23'd0);
        ib = (eb == 8'hff) && (i_b[22:0] == 23'd0);
        na = (ea == 8'hff) && (i_a[22:0] != 23'd0);
        nb = (eb == 8'hff) && (i_b[22:0] != 23'd0);
        n_unp.sign = i_a[31] ^ i_b[31];
        if (na || nb || (ia && zb) || (ib && za)) begin
            n_unp.cls = fmr_pkg::t_cls_nan;
        end else if (ia || ib) begin
            n_unp.cls = fmr_pkg::t_cls_inf;
        end else if (za || zb) begin
            n_unp.cls = fmr_pkg::t_cls_zero;
        end else begin
            n_unp.cls = fmr_pkg::t_cls_num;
        end
        // Subnormals: exponent 1, no hidden bit
        n_unp.exp_sum = {2'b00, (ea == 8'd0) ? 8'd1 : ea}
                      + {2'b00, (eb == 8'd0) ? 8'd1 : eb};
        n_unp.ma = {(ea != 8'd0), i_a[22:0]};
        n_unp.mb = {(eb != 8'd0), i_b[22:0]};
    end

    // Multiply mantissas
    always_comb begin
        n_mul.sign    = r_unp.sign;
        n_mul.cls     = r_unp.cls;
        n_mul.exp_sum = r_unp.exp_sum;
        n_mul.prod    = r_unp.ma * r_unp.mb;
    end

    // Normalise the product; align a subnormal result to the minimum exponent.
    // Value = prod * 2^(exp_sum - 254 - 46).
    always_comb begin
        logic [5:0]  lz;
        logic        found;
        logic [ProdW_L-1:0] norm;
        logic signed [11:0] e;      // exponent of leading bit of rounded value
        logic signed [11:0] sh;     // extra right shift for subnormal result
        logic [ProdW_L:0]   shifted;
        logic        sticky;
        lz = 6'd0;
        found = 1'b0;
        for (int k = ProdW_L - 1; k >= 0; k--) begin
            if (!found && r_mul.prod[k]) begin
                found = 1'b1;
                lz = 6'(ProdW_L - 1 - k);
            end
        end
        norm = r_mul.prod << lz;
        // leading bit weight exponent (true, unbiased)
        e = $signed({2'b00, r_mul.exp_sum}) - 12'sd254 + 12'sd1 - $signed({6'd0, lz});
        // float32 min normal exponent -126
        sh = (e < -12'sd126) ? (-12'sd126 - e) : 12'sd0;
        if (sh > 12'sd30) begin
            shifted = '0;
            sticky  = |norm;
        end else begin
            shifted = {norm, 1'b0} >> sh[4:0];
            sticky  = |(norm & ((48'd1 << sh[4:0]) - 48'd1));
        end
        n_nrm.sign = r_mul.sign;
        n_nrm.cls  = r_mul.cls;
        n_nrm.m    = shifted[ProdW_L:ProdW_L-23];
        n_nrm.g    = shifted[ProdW_L-24];
        n_nrm.s    = sticky | (|shifted[ProdW_L-25:0]);
        n_nrm.ie   = (sh != 12'sd0) ? -12'sd126 : e;
    end

    // Round to float32 (nearest even), then truncate to a saturated integer
    always_comb begin
        logic [24:0] m;            // 24-bit mantissa + carry
        logic        rnd;
        logic [31:0] mag;
        logic signed [11:0] ie;
        rnd = r_nrm.g & (r_nrm.s | r_nrm.m[0]);
        m   = {1'b0, r_nrm.m} + {24'd0, rnd};
        ie  = $signed(r_nrm.ie);
        if (m[24]) begin
            m  = m >> 1;
            ie = ie + 12'sd1;
        end
        // m is 1.23 fixed at weight 2^ie; integer part = m >> (23 - ie)
        if (ie < 12'sd0) begin
            mag = 32'd0;
        end else if (ie > 12'sd23) begin
            mag = (ie > 12'sd31) ? 32'hffff_ffff : ({8'd0, m[23:0]} << (ie - 12'sd23));
        end else begin
            mag = {8'd0, m[23:0]} >> (12'sd23 - ie);
        end
        case (r_nrm.cls)
            fmr_pkg::t_cls_nan:  n_fix = '0;
            fmr_pkg::t_cls_zero: n_fix = '0;
            fmr_pkg::t_cls_inf:  n_fix = r_nrm.sign ? fmr_pkg::FixMin : fmr_pkg::FixMax;
            default: begin
                if (ie > 12'sd30) begin
                    n_fix = r_nrm.sign ? fmr_pkg::FixMin : fmr_pkg::FixMax;
                end else begin
                    n_fix = r_nrm.sign ? (32'd0 - mag) : mag;
                end
            end
        endcase
    end

    // Advance the lane stages when enabled
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_unp <= n_unp;
            r_mul <= n_mul;
            r_nrm <= n_nrm;
            r_fix <= n_fix;
        end
    end

    assign o_fix = r_fix;

endmodule

// File: rtl/float_matrix_row_to_fixed_pack_core.sv
// Top level: float32 matrix row to packed s15.16 words, four lanes, 4-stage pipe.
// Depends on fmr_pkg, fmr_conv_lane and the assertion macro header.
//
//  channel  | direction | tdata (low bit up)                               | tlast
//  s_axis   | in        | element_0..element_3, row_number (130b -> 136b)  | batch_last
//  m_axis   | out       | out_row_number, int_a, int_b, frac_a, frac_b     | out_last
//  cfg      | in        | i_cfg_we, i_cfg_index, i_cfg_data                 | -
//
// One item per cycle while the output is not stalled; items pass through unpack,
// multiply, normalise, round and convert.
// Reset clears stage valid bits and loads both scales with 65536.0.
// The whole pipe advances when the output stage is empty or being taken.
`include "float_matrix_row_to_fixed_pack_core_assert.svh"
module float_matrix_row_to_fixed_pack_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // element_0[31:0], element_1[63:32], element_2[95:64], element_3[127:96],
    // row_number[129:128], zero fill
    input  logic [135:0] s_axis_tdata,
    // batch_last
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_row_number[1:0], integer_word_a[33:2], integer_word_b[65:34],
    // fraction_word_a[97:66], fraction_word_b[129:98], zero fill
    output logic [135:0] m_axis_tdata,
    // out_last
    output logic         m_axis_tlast,
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    localparam int unsigned Depth = fmr_pkg::PipeDepth;
    localparam int unsigned EW    = fmr_pkg::ElemW;
    localparam int unsigned HW    = fmr_pkg::HalfW;

    logic [EW-1:0] r_lin, r_trans;
    logic [Depth-1:0] r_vld;
    logic [fmr_pkg::RowW-1:0] r_row [Depth];
    logic [Depth-1:0] r_last;
    logic adv;
    logic [EW-1:0] fix [fmr_pkg::NumElem];

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin   <= fmr_pkg::ScaleReset;
            r_trans <= fmr_pkg::ScaleReset;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fmr_pkg::CfgLinear:      r_lin   <= i_cfg_data;
                fmr_pkg::CfgTranslation: r_trans <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign adv           = !r_vld[Depth-1] || m_axis_tready;
    assign s_axis_tready = adv;

    // Advance valid bits and side fields with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[Depth-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_row[0]  <= s_axis_tdata[129:128];
            r_last[0] <= s_axis_tlast;
            for (int k = 1; k < Depth; k++) begin
                r_row[k]  <= r_row[k-1];
                r_last[k] <= r_last[k-1];
            end
        end
    end

    // Four conversion lanes
    for (genvar g = 0; g < fmr_pkg::NumElem; g++) begin : g_lane
        fmr_conv_lane u_lane (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_a   (s_axis_tdata[g*EW +: EW]),
            .i_b   ((g == fmr_pkg::NumElem - 1) ? r_trans : r_lin),
            .o_fix (fix[g])
        );
    end

    assign m_axis_tvalid = r_vld[Depth-1];
    assign m_axis_tlast  = r_last[Depth-1];
    assign m_axis_tdata  = {6'd0,
                            fix[2][HW-1:0],  fix[3][HW-1:0],
                            fix[0][HW-1:0],  fix[1][HW-1:0],
                            fix[2][EW-1:HW], fix[3][EW-1:HW],
                            fix[0][EW-1:HW], fix[1][EW-1:HW],
                            r_row[Depth-1]};

    `FMR_ASSERT(a_stall_holds, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled output item changed")
    `FMR_ASSERT(a_ready_free, i_clk, i_rst_n, !m_axis_tvalid |-> s_axis_tready, "input blocked with empty output")
    `FMR_ASSERT(a_pipe_flow, i_clk, i_rst_n, (s_axis_tvalid && s_axis_tready) |=> r_vld[0], "accepted item lost at entry")
    `FMR_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> r_vld == '0, "valid bits not cleared by reset")

endmodule
